@@ src/icm_pkg.sv @@
// ----------------------------------------------------------------------------
// icm_pkg
// Shared types and constants for the Ising chain Metropolis step block.
// ----------------------------------------------------------------------------
package icm_pkg;

    // Fixed field widths of the input and result words.
    localparam int SITE_W       = 7;
    localparam int DRAW_W       = 16;
    localparam int THR_W        = 16;
    localparam int ENERGY_OUT_W = 8;
    localparam int CFG_IDX_W    = 2;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THR_TWO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR = 2'd1;

    // Threshold reset values, fractions of 65536.
    localparam logic [THR_W-1:0] THR_TWO_RESET  = 16'd8869;
    localparam logic [THR_W-1:0] THR_FOUR_RESET = 16'd1200;

    // Which spin the memory read port fetches this cycle.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_LEFT,
        RD_CENTER,
        RD_RIGHT
    } rd_sel_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_L,
        ST_READ_C,
        ST_READ_R,
        ST_EVAL
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clear_step;
        logic    load_item;
        rd_sel_t rd_sel;
        logic    cap_left;
        logic    cap_center;
        logic    commit;
    } icm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } icm_status_t;

endpackage

@@ src/icm_ctrl.sv @@
// ----------------------------------------------------------------------------
// icm_ctrl
// Sequencer: clears the spin memory after reset, then walks each word
// through three neighbor reads and an evaluate/commit step.
// ----------------------------------------------------------------------------
module icm_ctrl
    import icm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  icm_status_t status,
    output icm_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ_L;
                end
            end
            ST_READ_L: state_next = ST_READ_C;
            ST_READ_C: state_next = ST_READ_R;
            ST_READ_R: state_next = ST_EVAL;
            ST_EVAL: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Output decode.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_READ_L: cmd.rd_sel = RD_LEFT;
            ST_READ_C: begin
                cmd.rd_sel   = RD_CENTER;
                cmd.cap_left = 1'b1;
            end
            ST_READ_R: begin
                cmd.rd_sel     = RD_RIGHT;
                cmd.cap_center = 1'b1;
            end
            ST_EVAL: cmd.commit = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

@@ src/icm_datapath.sv @@
// ----------------------------------------------------------------------------
// icm_datapath
// Spin memory, energy register, thresholds, acceptance test and the
// output register of the Ising chain Metropolis step block.
// ----------------------------------------------------------------------------
module icm_datapath
    import icm_pkg::*;
#(
    parameter int SITES = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  icm_cmd_t                       cmd,
    output icm_status_t                    status,
    input  logic                           in_operation,
    input  logic [SITE_W-1:0]              in_site,
    input  logic                           in_spin_value,
    input  logic [DRAW_W-1:0]              in_random_draw,
    input  logic                           cfg_valid,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [THR_W-1:0]               cfg_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_changed,
    output logic                           m_spin_after,
    output logic signed [ENERGY_OUT_W-1:0] m_total_energy
);

    localparam int AW    = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int E_W   = $clog2(SITES) + 2;
    localparam int CMP_W = E_W + ENERGY_OUT_W;

    // Spin memory and its read register.
    logic          spin_mem [SITES];
    logic          rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    // Clearing pass address.
    logic [AW-1:0] clr_addr_reg;

    // Item registers.
    logic              op_reg;
    logic [SITE_W-1:0] site_reg;
    logic              val_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic              left_reg;
    logic              center_reg;

    // Thresholds and energy.
    logic [THR_W-1:0]      thr_two_reg;
    logic [THR_W-1:0]      thr_four_reg;
    logic signed [E_W-1:0] energy_reg;
    logic signed [E_W-1:0] energy_next;

    // Output register.
    logic                           out_valid_reg;
    logic                           changed_reg;
    logic                           spin_after_reg;
    logic signed [ENERGY_OUT_W-1:0] total_reg;

    // Decode of the addressed site.
    logic [31:0]           site_ext;
    logic                  in_range;
    logic                  left_present;
    logic                  right_present;
    logic [AW-1:0]         left_addr;
    logic [AW-1:0]         center_addr;
    logic [AW-1:0]         right_addr;
    logic signed [2:0]     left_val;
    logic signed [2:0]     right_val;
    logic signed [2:0]     nb_sum;
    logic signed [3:0]     de_pos;
    logic signed [3:0]     de;
    logic                  flip;
    logic                  do_flip;
    logic signed [CMP_W-1:0] e_wide;
    logic signed [ENERGY_OUT_W-1:0] e_sat;

    assign site_ext      = 32'(site_reg);
    assign in_range      = site_ext < 32'(SITES);
    assign left_present  = in_range && (site_reg != '0);
    assign right_present = in_range && ((site_ext + 32'd1) < 32'(SITES));
    assign left_addr     = left_present  ? AW'(site_ext - 32'd1) : '0;
    assign center_addr   = in_range      ? AW'(site_ext)         : '0;
    assign right_addr    = right_present ? AW'(site_ext + 32'd1) : '0;

    // Read address select.
    always_comb begin
        unique case (cmd.rd_sel)
            RD_LEFT:   rd_addr = left_addr;
            RD_CENTER: rd_addr = center_addr;
            RD_RIGHT:  rd_addr = right_addr;
            RD_NONE:   rd_addr = '0;
            default:   rd_addr = '0;
        endcase
    end

    // Energy change of flipping the center spin; the right spin is in the read register.
    assign left_val  = !left_present  ? 3'sd0 : (left_reg    ? -3'sd1 : 3'sd1);
    assign right_val = !right_present ? 3'sd0 : (rd_data_reg ? -3'sd1 : 3'sd1);
    assign nb_sum    = left_val + right_val;
    assign de_pos    = signed'({nb_sum, 1'b0});
    assign de        = center_reg ? -de_pos : de_pos;

    // Acceptance decision.
    always_comb begin
        if (op_reg == OP_LOAD) begin
            flip = (val_reg != center_reg);
        end else if (de <= 4'sd0) begin
            flip = 1'b1;
        end else if (de == 4'sd2) begin
            flip = draw_reg < thr_two_reg;
        end else begin
            flip = draw_reg < thr_four_reg;
        end
    end

    assign do_flip     = in_range && flip;
    assign energy_next = do_flip ? (energy_reg + E_W'(de)) : energy_reg;

    // Saturate the exact energy to the output range.
    assign e_wide = CMP_W'(energy_next);
    always_comb begin
        if (e_wide > CMP_W'(127)) begin
            e_sat = 8'sd127;
        end else if (e_wide < CMP_W'(-127)) begin
            e_sat = -8'sd127;
        end else begin
            e_sat = e_wide[ENERGY_OUT_W-1:0];
        end
    end

    // Memory write port: clearing pass or committed flip.
    assign wr_en   = cmd.clear_step || (cmd.commit && do_flip);
    assign wr_addr = cmd.clear_step ? clr_addr_reg : center_addr;
    assign wr_data = cmd.clear_step ? 1'b0 : ~center_reg;

    // Spin memory with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            spin_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_sel != RD_NONE) begin
            rd_data_reg <= spin_mem[rd_addr];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step && (clr_addr_reg != AW'(SITES - 1))) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign status.clear_last = (clr_addr_reg == AW'(SITES - 1));
    assign status.out_free   = !out_valid_reg || m_ready;

    // Item and neighbor capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= in_operation;
            site_reg <= in_site;
            val_reg  <= in_spin_value;
            draw_reg <= in_random_draw;
        end
        if (cmd.cap_left) begin
            left_reg <= rd_data_reg;
        end
        if (cmd.cap_center) begin
            center_reg <= rd_data_reg;
        end
    end

    // Threshold registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_two_reg  <= THR_TWO_RESET;
            thr_four_reg <= THR_FOUR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_THR_TWO:  thr_two_reg  <= cfg_data;
                REG_THR_FOUR: thr_four_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Energy register; reset is the aligned chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= E_W'(-(SITES - 1));
        end else if (cmd.commit) begin
            energy_reg <= energy_next;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            changed_reg    <= do_flip;
            spin_after_reg <= in_range ? (center_reg ^ flip) : 1'b0;
            total_reg      <= e_sat;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_changed      = changed_reg;
    assign m_spin_after   = spin_after_reg;
    assign m_total_energy = total_reg;

    // A commit never overwrites a word that has not been taken.
    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_ready))
        else $error("commit while output word still pending");

    // The exact energy stays within the range of an open chain.
    a_energy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (energy_reg >= E_W'(-(SITES - 1))) && (energy_reg <= E_W'(SITES - 1)))
        else $error("chain energy out of range");

    // A commit always presents a word on the next cycle.
    a_commit_shows_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("committed word not presented");

    // The energy register only moves on a commit that flips a spin.
    a_energy_moves_on_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && do_flip) |=> $stable(energy_reg))
        else $error("energy changed without a flip");

endmodule

@@ src/ising_chain_metropolis_step.sv @@
// ----------------------------------------------------------------------------
// ising_chain_metropolis_step
// Open 1-D Ising chain with Metropolis single-spin updates and a running
// chain energy, thresholds replacing the Boltzmann exponential.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word contents
//  s_       in         operation, site, spin_value, random_draw
//  m_       out        changed, spin_after, total_energy
//  cfg_     in         cfg_index (0: threshold for +2J, 1: for +4J), cfg_data
//
//  Each word passes through accept, three reads of the single spin
//  memory read port (left, center, right neighbor), then evaluate and commit.
//  After reset a clearing pass zeroes the spin memory; no input word is
//  accepted during it, configuration writes are always taken.
//  A stalled result waits in the output register; the next word can be
//  accepted meanwhile and holds in its commit cycle until the register frees.
// ----------------------------------------------------------------------------
module ising_chain_metropolis_step
    import icm_pkg::*;
#(
    parameter int SITES = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [SITE_W-1:0]              s_site,
    input  logic                           s_spin_value,
    input  logic [DRAW_W-1:0]              s_random_draw,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_changed,
    output logic                           m_spin_after,
    output logic signed [ENERGY_OUT_W-1:0] m_total_energy,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [THR_W-1:0]               cfg_data
);

    icm_cmd_t    cmd;
    icm_status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    icm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    icm_datapath #(
        .SITES (SITES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_operation   (s_operation),
        .in_site        (s_site),
        .in_spin_value  (s_spin_value),
        .in_random_draw (s_random_draw),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_changed      (m_changed),
        .m_spin_after   (m_spin_after),
        .m_total_energy (m_total_energy)
    );

endmodule
